// ===== src/mec_pkg.sv =====
package mec_pkg;

	localparam int PALETTE_SIZE_DEF = 128;
	localparam int FX_W = 36;
	localparam int HALF_W = 18;
	localparam int PROD_W = 72;
	localparam int PP_W = FX_W + HALF_W;
	localparam int THR_W = 34;
	localparam int ITER_CFG_W = 8;
	localparam int IDX_W = 7;
	localparam int COLOR_W = 8;
	localparam int CFG_DATA_W = 34;
	localparam logic [THR_W-1:0] THR_RESET = 34'd1342177280;
	localparam logic [ITER_CFG_W-1:0] MAX_ITER_RESET = 8'd128;

	typedef enum logic [0:0] {
		REG_THRESHOLD = 1'b0,
		REG_MAX_ITER  = 1'b1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_DECIDE,
		ST_DONE
	} iter_state_t;

	typedef struct packed {
		logic valid;
		logic hi;
	} mac_ctl_t;

	typedef struct packed {
		logic [COLOR_W-1:0] blue;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] red;
		logic [IDX_W-1:0]   escape_index;
		logic               inside_res;
	} res_t;

	function automatic logic [FX_W-1:0] fx_mag(input logic signed [FX_W-1:0] a);
		fx_mag = a[FX_W-1] ? FX_W'(-a) : FX_W'(a);
	endfunction

	// Drops the fraction bits of a magnitude product, caps it at the Q8.28 bound
	// and applies the sign.
	function automatic logic signed [FX_W-1:0] fx_scale(
		input logic [PROD_W-1:0] prod,
		input logic              sh27,
		input logic              neg
	);
		logic [PROD_W-28:0] m;
		logic [PROD_W-28:0] cap;
		logic [FX_W-1:0]    m36;
		m = sh27 ? prod[PROD_W-1:27] : {1'b0, prod[PROD_W-1:28]};
		cap = neg ? (PROD_W-27)'(36'h8_0000_0000) : (PROD_W-27)'(36'h7_FFFF_FFFF);
		if (m > cap) begin
			m = cap;
		end
		m36 = m[FX_W-1:0];
		fx_scale = neg ? $signed(-m36) : $signed(m36);
	endfunction

	function automatic logic signed [FX_W-1:0] fx_sat(input logic signed [FX_W+1:0] x);
		if (x > 38'sh0_7_FFFF_FFFF) begin
			fx_sat = 36'sh7_FFFF_FFFF;
		end else if (x < -38'sh0_8_0000_0000) begin
			fx_sat = 36'sh8_0000_0000;
		end else begin
			fx_sat = x[FX_W-1:0];
		end
	endfunction

	function automatic logic [3*COLOR_W-1:0] palette_rgb(input logic [IDX_W-1:0] i);
		logic [4:0]         j;
		logic [COLOR_W-1:0] j8;
		logic [COLOR_W-1:0] j4;
		logic [COLOR_W-1:0] r;
		logic [COLOR_W-1:0] g;
		logic [COLOR_W-1:0] b;
		j = i[4:0];
		j8 = {j, 3'b000};
		j4 = {1'b0, j, 2'b00};
		case (i[6:5])
			2'd0: begin
				r = j8;
				g = 8'd128 - j4;
				b = 8'd255 - j8;
			end
			2'd1: begin
				r = 8'd255;
				g = j8;
				b = 8'd0;
			end
			2'd2: begin
				r = 8'd128 - j4;
				g = 8'd255;
				b = j8;
			end
			default: begin
				r = 8'd0;
				g = 8'd255 - j8;
				b = j8;
			end
		endcase
		palette_rgb = {b, g, r};
	endfunction

endpackage

// ===== src/mec_mac.sv =====
module mec_mac
	import mec_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  mac_ctl_t          ctl,
	input  logic [FX_W-1:0]   op_a,
	input  logic [HALF_W-1:0] op_b,
	output logic [PROD_W-1:0] acc
);

	logic [PP_W-1:0]   pp_s1;
	logic              hi_s1;
	logic              valid_s1;
	logic [PROD_W-1:0] acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= ctl.valid;
		end
	end

	always_ff @(posedge clk) begin
		pp_s1 <= op_a * op_b;
		hi_s1 <= ctl.hi;
		if (valid_s1) begin
			if (hi_s1) begin
				acc_q <= acc_q + {pp_s1, {HALF_W{1'b0}}};
			end else begin
				acc_q <= {{(PROD_W-PP_W){1'b0}}, pp_s1};
			end
		end
	end

	assign acc = acc_q;

endmodule

// ===== src/mec_iter.sv =====
module mec_iter
	import mec_pkg::*;
#(
	parameter int PALETTE_SIZE = PALETTE_SIZE_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic signed [31:0]    c_real,
	input  logic signed [31:0]    c_imag,
	input  logic [THR_W-1:0]      thr,
	input  logic [ITER_CFG_W-1:0] max_iter,
	input  logic                  res_ready,
	output logic                  idle,
	output logic                  res_valid,
	output res_t                  res
);

	localparam int ItW = $clog2(PALETTE_SIZE + 1);

	iter_state_t state_q, state_d;
	logic [2:0]              step_q;
	logic [ItW-1:0]          it_q;
	logic [ItW-1:0]          lim;
	logic signed [31:0]      cr_q;
	logic signed [31:0]      ci_q;
	logic signed [FX_W-1:0]  re_q;
	logic signed [FX_W-1:0]  im_q;
	logic [FX_W-2:0]         rr_q;
	logic [FX_W-2:0]         ii_q;
	logic signed [FX_W-1:0]  ri_q;
	res_t                    res_q;

	mac_ctl_t                mac_ctl;
	logic [FX_W-1:0]         re_mag;
	logic [FX_W-1:0]         im_mag;
	logic [FX_W-1:0]         op_a;
	logic [FX_W-1:0]         op_b_full;
	logic [HALF_W-1:0]       op_b;
	logic [PROD_W-1:0]       acc;
	logic signed [FX_W+1:0]  re_sum;
	logic signed [FX_W+1:0]  im_sum;
	logic [FX_W-1:0]         mag_sum;
	logic                    escaped;
	logic                    load;
	logic                    update;
	logic                    finish_esc;
	logic                    finish_in;

	assign lim = (32'(max_iter) > PALETTE_SIZE) ? ItW'(PALETTE_SIZE) : ItW'(max_iter);

	assign re_mag = fx_mag(re_q);
	assign im_mag = fx_mag(im_q);

	always_comb begin
		case (step_q[2:1])
			2'd0: begin
				op_a = re_mag;
				op_b_full = re_mag;
			end
			2'd1: begin
				op_a = im_mag;
				op_b_full = im_mag;
			end
			default: begin
				op_a = re_mag;
				op_b_full = im_mag;
			end
		endcase
	end

	assign op_b = step_q[0] ? op_b_full[FX_W-1:HALF_W] : op_b_full[HALF_W-1:0];

	mec_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mac_ctl),
		.op_a   (op_a),
		.op_b   (op_b),
		.acc    (acc)
	);

	assign re_sum = $signed({3'b000, rr_q}) - $signed({3'b000, ii_q}) + (FX_W+2)'(cr_q);
	assign im_sum = (FX_W+2)'(ri_q) + (FX_W+2)'(ci_q);
	assign mag_sum = {1'b0, rr_q} + {1'b0, ii_q};
	assign escaped = (it_q != '0) && (mag_sum > {2'b00, thr});

	always_comb begin
		state_d = state_q;
		mac_ctl = '0;
		load = 1'b0;
		update = 1'b0;
		finish_esc = 1'b0;
		finish_in = 1'b0;
		idle = 1'b0;
		res_valid = 1'b0;
		case (state_q)
			ST_IDLE: begin
				idle = 1'b1;
				if (start) begin
					load = 1'b1;
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				mac_ctl.valid = (step_q[2:1] != 2'd3);
				mac_ctl.hi = step_q[0];
				if (step_q == 3'd7) begin
					state_d = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				if (escaped) begin
					finish_esc = 1'b1;
					state_d = ST_DONE;
				end else if (it_q == lim) begin
					finish_in = 1'b1;
					state_d = ST_DONE;
				end else begin
					update = 1'b1;
					state_d = ST_MUL;
				end
			end
			ST_DONE: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q <= '0;
			it_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_MUL) begin
				step_q <= step_q + 3'd1;
			end else begin
				step_q <= '0;
			end
			if (load) begin
				it_q <= '0;
			end else if (update) begin
				it_q <= it_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cr_q <= c_real;
			ci_q <= c_imag;
			re_q <= FX_W'(c_real);
			im_q <= FX_W'(c_imag);
		end else if (update) begin
			re_q <= fx_sat(re_sum);
			im_q <= fx_sat(im_sum);
		end
		if (state_q == ST_MUL) begin
			case (step_q)
				3'd3: rr_q <= (FX_W-1)'(fx_scale(acc, 1'b0, 1'b0));
				3'd5: ii_q <= (FX_W-1)'(fx_scale(acc, 1'b0, 1'b0));
				3'd7: ri_q <= fx_scale(acc, 1'b1, re_q[FX_W-1] ^ im_q[FX_W-1]);
				default: begin
				end
			endcase
		end
		if (finish_esc) begin
			res_q.inside_res <= 1'b0;
			res_q.escape_index <= IDX_W'(it_q - 1'b1);
			{res_q.blue, res_q.green, res_q.red} <= palette_rgb(IDX_W'(it_q - 1'b1));
		end else if (finish_in) begin
			res_q.inside_res <= 1'b1;
			res_q.escape_index <= '0;
			{res_q.blue, res_q.green, res_q.red} <= '0;
		end
	end

	assign res = res_q;

endmodule

// ===== src/mandelbrot_escape_colorizer_unit.sv =====
// Channel   Direction  Item                           Accepted when
// s_axis    in         c_real, c_imag (Q4.28)         s_axis_tvalid && s_axis_tready
// m_axis    out        inside flag, index, RGB888     m_axis_tvalid && m_axis_tready
// cfg       in         threshold, iteration limit     cfg_we
//
// Each pass over z runs through the MUL and DECIDE states: six issues into the one 36x18
// multiplier for re*re, im*im and re*im, the drain of its pipeline, and a decide step.
// The input is ready only while the iterator is idle; one finished item waits in the
// output register, so the next item may enter while it is stalled.
// Reset clears the handshake and sequencer state and loads the register defaults.
module mandelbrot_escape_colorizer_unit
	import mec_pkg::*;
#(
	parameter int PALETTE_SIZE = PALETTE_SIZE_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// [31:0] c_real, [63:32] c_imag
	input  logic [63:0]           s_axis_tdata,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// [6:0] escape_index, [14:7] red, [22:15] green, [30:23] blue, [31] zero
	output logic [31:0]           m_axis_tdata,
	// [0] inside_res
	output logic [0:0]            m_axis_tuser,
	input  logic                  cfg_we,
	input  logic [0:0]            cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic [THR_W-1:0]      thr_q;
	logic [ITER_CFG_W-1:0] max_iter_q;
	logic                  out_valid_q;
	res_t                  out_res_q;
	logic                  core_idle;
	logic                  core_valid;
	logic                  core_ready;
	res_t                  core_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
			max_iter_q <= MAX_ITER_RESET;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_THRESHOLD: thr_q <= cfg_data[THR_W-1:0];
				REG_MAX_ITER:  max_iter_q <= cfg_data[ITER_CFG_W-1:0];
				default: begin
				end
			endcase
		end
	end

	mec_iter #(
		.PALETTE_SIZE (PALETTE_SIZE)
	) u_iter (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (s_axis_tvalid),
		.c_real    ($signed(s_axis_tdata[31:0])),
		.c_imag    ($signed(s_axis_tdata[63:32])),
		.thr       (thr_q),
		.max_iter  (max_iter_q),
		.res_ready (core_ready),
		.idle      (core_idle),
		.res_valid (core_valid),
		.res       (core_res)
	);

	assign s_axis_tready = core_idle;
	assign core_ready = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (core_valid && core_ready) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (core_valid && core_ready) begin
			out_res_q <= core_res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = {1'b0, out_res_q.blue, out_res_q.green, out_res_q.red,
		out_res_q.escape_index};
	assign m_axis_tuser = out_res_q.inside_res;

endmodule
